// ===== rtl/segx_pkg.sv =====
// Shared types, widths and status codes for the segment intersection block.
// No dependencies; every other file in rtl/ refers to this package.
package segx_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int DEN_W     = CROSS_W + 1;
  localparam int NUM_LO_W  = DEN_W / 2;
  localparam int NUM_HI_W  = DEN_W - NUM_LO_W;
  localparam int MAG_W     = DEN_W + COORD_W;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_SAME_AB  = 3'd1;
  localparam logic [2:0] ST_SHARED   = 3'd2;
  localparam logic [2:0] ST_NO_CROSS = 3'd3;
  localparam logic [2:0] ST_OUTSIDE  = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
  } seg_in_t;

  typedef struct packed {
    logic                      found;
    logic [2:0]                status;
    logic signed [COORD_W-1:0] cross_x;
    logic signed [COORD_W-1:0] cross_y;
  } seg_out_t;

  // Classified work handed from the front end to the divide back end.
  typedef struct packed {
    logic [2:0]                status;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic [COORD_W-1:0]        bx_mag;
    logic                      bx_neg;
    logic [COORD_W-1:0]        by_mag;
    logic                      by_neg;
    logic [DEN_W-1:0]          num;
    logic [DEN_W-1:0]          den;
  } job_t;

endpackage

// ===== rtl/segment_intersection.sv =====
// Top level of the segment intersection block: front end, job queue, back end.
// Depends on segx_pkg, segx_front, segx_queue and segx_back.
//
// One segment pair per clock: a pair is taken on any edge with start high and
// busy low, and its result appears on result with done high for one cycle.
// The latency is set mostly by the restoring divider, which produces one
// quotient bit per pipeline stage. The receiver cannot stall; results are
// never held. busy rises only if the job queue between the classifying
// front end and the divide back end could overflow, which does not happen
// in steady operation since the back end drains every cycle.
module segment_intersection #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  segx_pkg::seg_in_t   item,
  output logic                done,
  output segx_pkg::seg_out_t  result
);

  localparam int CNW     = $clog2(QUEUE_DEPTH + 1);
  localparam int LATENCY = segx_pkg::COORD_W + 7;

  logic                 take, push, pop;
  logic [1:0]           inflight;
  logic [CNW-1:0]       q_count;
  logic [CNW:0]         load;
  segx_pkg::job_t       front_job, back_job;

  assign take = start && !busy;
  assign load = (CNW+1)'(q_count) + (CNW+1)'(inflight);
  assign busy = load > (CNW+1)'(QUEUE_DEPTH);
  assign pop  = q_count != '0;

  segx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .inflight (inflight),
    .push     (push),
    .job      (front_job)
  );

  segx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_job),
    .pop   (pop),
    .rdata (back_job),
    .count (q_count)
  );

  segx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop),
    .job       (back_job),
    .done      (done),
    .result    (result)
  );

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.found == (result.status == segx_pkg::ST_FOUND)))
    else $error("found flag disagrees with status");

  a_zero_miss: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.cross_x == '0 && result.cross_y == '0))
    else $error("point not cleared on a miss");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (CNW+1)'(q_count) <= (CNW+1)'(QUEUE_DEPTH))
    else $error("job queue overflow");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##LATENCY done)
    else $error("transaction result missing at expected cycle");

endmodule

// ===== rtl/segx_front.sv =====
// Front end: accepts a segment pair, checks degenerate cases, forms the cross
// products and classifies the pair. Depends on segx_pkg.
module segx_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  segx_pkg::seg_in_t   item,
  output logic [1:0]          inflight,
  output logic                push,
  output segx_pkg::job_t      job
);

  localparam int W  = segx_pkg::COORD_W;
  localparam int DW = segx_pkg::DIFF_W;
  localparam int PW = segx_pkg::PROD_W;
  localparam int CW = segx_pkg::CROSS_W;
  localparam int NW = segx_pkg::DEN_W;

  typedef struct packed {
    logic [2:0]          status;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
  } meta_t;

  // stage 1: differences against A
  logic                 v1;
  meta_t                m1;
  logic signed [DW-1:0] bxd1, byd1, cxd1, cyd1, dxd1, dyd1;
  // stage 2: products
  logic                 v2;
  meta_t                m2;
  logic signed [DW-1:0] bxd2, byd2;
  logic signed [PW-1:0] pbc1, pbc2, pbd1, pbd2, pn1, pn2;
  // stage 3: cross sums
  logic                 v3;
  meta_t                m3;
  logic signed [DW-1:0] bxd3, byd3;
  logic signed [CW-1:0] sc, sd, num3;

  logic                 same_ab, shared;
  logic [2:0]           st1;
  logic signed [NW-1:0] den_s, num_s, den_u, num_u;
  logic [DW-1:0]        bx_abs, by_abs;
  logic [2:0]           st4;

  always_comb begin
    same_ab = (item.ax == item.bx) && (item.ay == item.by_coord);
    shared  = ((item.ax == item.cx) && (item.ay == item.cy)) ||
              ((item.bx == item.cx) && (item.by_coord == item.cy)) ||
              ((item.ax == item.dx) && (item.ay == item.dy)) ||
              ((item.bx == item.dx) && (item.by_coord == item.dy));
    if (same_ab) begin
      st1 = segx_pkg::ST_SAME_AB;
    end else if (shared) begin
      st1 = segx_pkg::ST_SHARED;
    end else begin
      st1 = segx_pkg::ST_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    m1   <= meta_t'{status: st1, ax: item.ax, ay: item.ay};
    bxd1 <= {item.bx[W-1], item.bx} - {item.ax[W-1], item.ax};
    byd1 <= {item.by_coord[W-1], item.by_coord} - {item.ay[W-1], item.ay};
    cxd1 <= {item.cx[W-1], item.cx} - {item.ax[W-1], item.ax};
    cyd1 <= {item.cy[W-1], item.cy} - {item.ay[W-1], item.ay};
    dxd1 <= {item.dx[W-1], item.dx} - {item.ax[W-1], item.ax};
    dyd1 <= {item.dy[W-1], item.dy} - {item.ay[W-1], item.ay};

    m2   <= m1;
    bxd2 <= bxd1;
    byd2 <= byd1;
    pbc1 <= bxd1 * cyd1;
    pbc2 <= byd1 * cxd1;
    pbd1 <= bxd1 * dyd1;
    pbd2 <= byd1 * dxd1;
    pn1  <= cxd1 * dyd1;
    pn2  <= cyd1 * dxd1;

    m3   <= m2;
    bxd3 <= bxd2;
    byd3 <= byd2;
    sc   <= CW'(pbc1) - CW'(pbc2);
    sd   <= CW'(pbd1) - CW'(pbd2);
    num3 <= CW'(pn1) - CW'(pn2);
  end

  // Normalize to a positive denominator, then classify.
  always_comb begin
    den_s  = NW'(sd) - NW'(sc);
    num_s  = NW'(num3);
    den_u  = den_s[NW-1] ? -den_s : den_s;
    num_u  = den_s[NW-1] ? -num_s : num_s;
    bx_abs = bxd3[DW-1] ? -bxd3 : bxd3;
    by_abs = byd3[DW-1] ? -byd3 : byd3;
    if (m3.status != segx_pkg::ST_FOUND) begin
      st4 = m3.status;
    end else if (sc[CW-1] == sd[CW-1]) begin
      st4 = segx_pkg::ST_NO_CROSS;
    end else if (num_u[NW-1] || (num_u > den_u)) begin
      st4 = segx_pkg::ST_OUTSIDE;
    end else begin
      st4 = segx_pkg::ST_FOUND;
    end
  end

  assign push     = v3;
  assign inflight = 2'(v1) + 2'(v2) + 2'(v3);
  assign job      = segx_pkg::job_t'{
    status: st4,
    ax:     m3.ax,
    ay:     m3.ay,
    bx_mag: bx_abs[W-1:0],
    bx_neg: bxd3[DW-1],
    by_mag: by_abs[W-1:0],
    by_neg: byd3[DW-1],
    num:    num_u,
    den:    den_u
  };

endmodule

// ===== rtl/segx_queue.sv =====
// Short queue of classified jobs between the front end and the back end.
// Depends on segx_pkg for the entry type.
module segx_queue #(
  parameter int DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  segx_pkg::job_t              wdata,
  input  logic                        pop,
  output segx_pkg::job_t              rdata,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  segx_pkg::job_t  entries [DEPTH];
  logic [AW-1:0]   wptr, rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNW'(push) - CNW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wdata;
    end
  end

  assign rdata = entries[rptr];

endmodule

// ===== rtl/segx_back.sv =====
// Back end: scales the position along A-B, divides by the denominator in a
// one-bit-per-stage pipeline and rounds toward zero. Depends on segx_pkg.
module segx_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  segx_pkg::job_t      job,
  output logic                done,
  output segx_pkg::seg_out_t  result
);

  localparam int W  = segx_pkg::COORD_W;
  localparam int NW = segx_pkg::DEN_W;
  localparam int LO = segx_pkg::NUM_LO_W;
  localparam int HI = segx_pkg::NUM_HI_W;
  localparam int MW = segx_pkg::MAG_W;

  typedef struct packed {
    logic [2:0]          status;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic                neg_x;
    logic                neg_y;
    logic [NW-1:0]       den;
  } meta_t;

  logic               b1_valid;
  meta_t              b1_meta;
  logic [LO+W-1:0]    px_lo, py_lo;
  logic [HI+W-1:0]    px_hi, py_hi;
  logic [MW-1:0]      tx, ty;

  logic               vld  [W+1];
  meta_t              meta [W+1];
  logic [NW-1:0]      rx   [W+1];
  logic [NW-1:0]      ry   [W+1];
  logic [W-1:0]       qx   [W+1];
  logic [W-1:0]       qy   [W+1];

  logic               rnz_x, rnz_y;
  logic signed [W+1:0] qex, qey, fx, fy, sx, sy, ox, oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      vld[0]   <= 1'b0;
    end else begin
      b1_valid <= job_valid;
      vld[0]   <= b1_valid;
    end
  end

  // split the scale multiply into two partial products per axis
  always_ff @(posedge clk) begin
    b1_meta <= meta_t'{status: job.status, ax: job.ax, ay: job.ay,
                       neg_x: job.bx_neg, neg_y: job.by_neg, den: job.den};
    px_lo   <= job.num[LO-1:0] * job.bx_mag;
    px_hi   <= job.num[NW-1:LO] * job.bx_mag;
    py_lo   <= job.num[LO-1:0] * job.by_mag;
    py_hi   <= job.num[NW-1:LO] * job.by_mag;
  end

  assign tx = MW'(px_lo) + (MW'(px_hi) << LO);
  assign ty = MW'(py_lo) + (MW'(py_hi) << LO);

  // quotient fits W bits, so the upper part of the dividend starts as remainder
  always_ff @(posedge clk) begin
    meta[0] <= b1_meta;
    rx[0]   <= tx[MW-1:W];
    ry[0]   <= ty[MW-1:W];
    qx[0]   <= tx[W-1:0];
    qy[0]   <= ty[W-1:0];
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [NW:0] trial_x, trial_y, diff_x, diff_y;
    logic        ge_x, ge_y;

    always_comb begin
      trial_x = {rx[k], qx[k][W-1]};
      trial_y = {ry[k], qy[k][W-1]};
      diff_x  = trial_x - {1'b0, meta[k].den};
      diff_y  = trial_y - {1'b0, meta[k].den};
      ge_x    = trial_x >= {1'b0, meta[k].den};
      ge_y    = trial_y >= {1'b0, meta[k].den};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      meta[k+1] <= meta[k];
      rx[k+1]   <= ge_x ? diff_x[NW-1:0] : trial_x[NW-1:0];
      ry[k+1]   <= ge_y ? diff_y[NW-1:0] : trial_y[NW-1:0];
      qx[k+1]   <= {qx[k][W-2:0], ge_x};
      qy[k+1]   <= {qy[k][W-2:0], ge_y};
    end
  end

  // floor the signed quotient, add A, then pull negative inexact sums up to zero
  always_comb begin
    rnz_x = |rx[W];
    rnz_y = |ry[W];
    qex   = {2'b00, qx[W]};
    qey   = {2'b00, qy[W]};
    fx    = meta[W].neg_x ? (-qex - (W+2)'(rnz_x)) : qex;
    fy    = meta[W].neg_y ? (-qey - (W+2)'(rnz_y)) : qey;
    sx    = {{2{meta[W].ax[W-1]}}, meta[W].ax} + fx;
    sy    = {{2{meta[W].ay[W-1]}}, meta[W].ay} + fy;
    ox    = sx + (W+2)'(sx[W+1] & rnz_x);
    oy    = sy + (W+2)'(sy[W+1] & rnz_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[W];
    end
  end

  always_ff @(posedge clk) begin
    result.status <= meta[W].status;
    if (meta[W].status == segx_pkg::ST_FOUND) begin
      result.found   <= 1'b1;
      result.cross_x <= ox[W-1:0];
      result.cross_y <= oy[W-1:0];
    end else begin
      result.found   <= 1'b0;
      result.cross_x <= '0;
      result.cross_y <= '0;
    end
  end

endmodule
